[hw/rtl/sine_cosine_unit_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sine/cosine unit
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SINE_COSINE_UNIT_CORE_MACROS_SVH
`define SINE_COSINE_UNIT_CORE_MACROS_SVH

// Same-cycle implication
`define SCU_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sine/cosine unit assertion failed");

// Next-cycle implication
`define SCU_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sine/cosine unit assertion failed");

`endif

[hw/rtl/scu_pkg.sv]
// ---------------------------------------------------------------------------
// scu_pkg
// Constants, intermediate types and single-precision helper functions.
// ---------------------------------------------------------------------------
package scu_pkg;

  // Single-precision constants
  localparam logic [31:0] C_PI         = 32'h40490FDA;
  localparam logic [31:0] C_TWO_PI     = 32'h40C90FDA;
  localparam logic [31:0] C_NEG_TWO_PI = 32'hC0C90FDA;
  localparam logic [31:0] C_HALF_PI    = 32'h3FC90FDA;
  localparam logic [31:0] C_THR_HALF   = 32'h4096CBE4;
  localparam logic [31:0] C_INV_TWO_PI = 32'h3E22F984;
  localparam logic [31:0] C_DEG_RAD    = 32'h3C8EFA35;
  localparam logic [31:0] C_NINETY     = 32'h42B40000;
  localparam logic [31:0] C_COEF3      = 32'hBE2AAAAB;
  localparam logic [31:0] C_COEF5      = 32'h3C088889;
  localparam logic [31:0] C_COEF7      = 32'hB9500D01;
  localparam logic [31:0] C_COEF9      = 32'h3638EF1D;
  localparam logic [31:0] C_ONE        = 32'h3F800000;
  localparam logic [31:0] C_NEG_ONE    = 32'hBF800000;
  localparam logic [31:0] C_NEG_ZERO   = 32'h80000000;
  localparam logic [31:0] C_QNAN       = 32'h7FC00000;

  // Operation codes carried in the user field
  localparam logic [1:0] OP_SIN_RAD = 2'd0;
  localparam logic [1:0] OP_COS_RAD = 2'd1;
  localparam logic [1:0] OP_SIN_DEG = 2'd2;
  localparam logic [1:0] OP_COS_DEG = 2'd3;

  // Unrounded result: value = m * 2^-48 * 2^(e-127), or a special value
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               s;
    logic signed [11:0] e;
    logic [49:0]        m;
  } scu_unp_t;

  // Register enables of one two-stage arithmetic unit
  typedef struct packed {
    logic en_a;
    logic en_b;
  } scu_ctl_t;

  function automatic logic fp_is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // Ordered less-than; false when either side is NaN
  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      r = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  // Round toward zero to an integral value
  function automatic logic [31:0] fp_trunc(logic [31:0] a);
    logic [31:0] r;
    logic [7:0]  sh;
    sh = 8'd150 - a[30:23];
    if (a[30:23] >= 8'd150) begin
      r = a;
    end else if (a[30:23] < 8'd127) begin
      r = {a[31], 31'd0};
    end else begin
      r = a & ~((32'd1 << sh[4:0]) - 32'd1);
    end
    return r;
  endfunction

  // Multiply front end: specials, mantissa product
  function automatic scu_unp_t fmul_pre(logic [31:0] a, logic [31:0] b);
    scu_unp_t   u;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic [47:0] prod;
    u.s        = a[31] ^ b[31];
    u.spec     = 1'b0;
    u.spec_val = C_QNAN;
    if (fp_is_nan(a) || fp_is_nan(b) ||
        (fp_is_inf(a) && (b[30:0] == 31'd0)) ||
        (fp_is_inf(b) && (a[30:0] == 31'd0))) begin
      u.spec = 1'b1;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      u.spec     = 1'b1;
      u.spec_val = {u.s, 8'hFF, 23'd0};
    end
    ma   = {(a[30:23] != 8'd0), a[22:0]};
    mb   = {(b[30:23] != 8'd0), b[22:0]};
    ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    prod = ma * mb;
    u.m  = {2'b00, prod};
    u.e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd125;
    return u;
  endfunction

  // Add front end: specials, alignment and mantissa add
  function automatic scu_unp_t fadd_pre(logic [31:0] a, logic [31:0] b);
    scu_unp_t    u;
    logic [31:0] bg, sm;
    logic [23:0] mg, ms;
    logic [7:0]  eg, es, d;
    logic [47:0] al;
    logic [95:0] w;
    u.spec     = 1'b0;
    u.spec_val = C_QNAN;
    if (fp_is_nan(a) || fp_is_nan(b) ||
        (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))) begin
      u.spec = 1'b1;
    end else if (fp_is_inf(a)) begin
      u.spec     = 1'b1;
      u.spec_val = a;
    end else if (fp_is_inf(b)) begin
      u.spec     = 1'b1;
      u.spec_val = b;
    end
    // order by magnitude
    if (b[30:0] > a[30:0]) begin
      bg = b;
      sm = a;
    end else begin
      bg = a;
      sm = b;
    end
    mg = {(bg[30:23] != 8'd0), bg[22:0]};
    ms = {(sm[30:23] != 8'd0), sm[22:0]};
    eg = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d  = eg - es;
    // align the smaller operand, jam lost bits into the lowest bit
    w  = {ms, 24'd0, 48'd0} >> d[6:0];
    if (d >= 8'd48) begin
      al = {47'd0, (ms != 24'd0)};
    end else begin
      al = w[95:48] | {47'd0, (w[47:0] != 48'd0)};
    end
    if (a[31] == b[31]) begin
      u.m = {2'b00, mg, 24'd0} + {2'b00, al};
    end else begin
      u.m = {2'b00, mg, 24'd0} - {2'b00, al};
    end
    u.e = $signed({4'd0, eg}) + 12'sd1;
    u.s = (u.m == 50'd0) ? (a[31] & b[31]) : bg[31];
    return u;
  endfunction

  // Normalise, round to nearest even and pack
  function automatic logic [31:0] fp_pack(scu_unp_t u);
    logic [5:0]         p;
    logic signed [11:0] en, amt, nsh;
    logic [7:0]         fld;
    logic [99:0]        w;
    logic [49:0]        x;
    logic               stk, inc;
    logic [30:0]        body;
    logic [31:0]        r;
    p = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (u.m[i]) p = i[5:0];
    end
    en = u.e + $signed({6'd0, p}) - 12'sd48;
    if (en >= 12'sd1) begin
      amt = $signed({6'd0, p}) - 12'sd48;
      fld = en[7:0];
    end else begin
      amt = 12'sd1 - u.e;
      fld = 8'd0;
    end
    nsh = -amt;
    w   = {u.m, 50'd0} >> amt[5:0];
    if (amt >= 12'sd51) begin
      x   = 50'd0;
      stk = (u.m != 50'd0);
    end else if (amt >= 12'sd0) begin
      x   = w[99:50];
      stk = (w[49:0] != 50'd0);
    end else begin
      x   = u.m << nsh[5:0];
      stk = 1'b0;
    end
    stk  = stk | (x[23:0] != 24'd0);
    inc  = x[24] & (stk | x[25]);
    body = {fld, x[47:25]} + {30'd0, inc};
    if (u.spec) begin
      r = u.spec_val;
    end else if (u.m == 50'd0) begin
      r = {u.s, 31'd0};
    end else if (en >= 12'sd255) begin
      r = {u.s, 8'hFF, 23'd0};
    end else begin
      r = {u.s, body};
    end
    return r;
  endfunction

endpackage

[hw/rtl/sine_cosine_unit_core.sv]
// ---------------------------------------------------------------------------
// sine_cosine_unit_core
// Pipelined single-precision sine and cosine with a Taylor kernel.
// ---------------------------------------------------------------------------
// One item enters per cycle while the output drains; its result passes through
// twenty-nine register stages, made of fourteen dependent float operations of
// two register stages each (pre-scale, range reduction, fold, polynomial) plus
// the clamp register. Every stage holds its item when the one after it is full,
// so a stalled output only blocks input once the pipeline has filled; s_tready
// follows from that chain of stages.
module sine_cosine_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] angle_bits
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] value_bits
);
  import scu_pkg::*;

  `include "sine_cosine_unit_core_macros.svh"

  localparam int NS = 29;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic [1:0]  req_sr [0:1];
  logic [31:0] a2_sr  [0:3];
  logic [31:0] x_sr   [0:5];
  logic [31:0] z_sr   [0:5];

  logic [31:0] k0, k1, qv, fb, ga, gb;
  logic [31:0] a1, a2, mq, pr, a3, a4, xg, z, t1, p3, t2;
  logic [31:0] r1, p5, t3, r2, p7, t4, r3, p9, r4, res;
  logic        c_hi, c_mid;

  // Stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];
  assign m_tdata  = res;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Hold side operands alongside the units that need them later
  always_ff @(posedge clk) begin
    if (en[0]) req_sr[0] <= s_tuser;
    if (en[1]) req_sr[1] <= req_sr[0];
    if (en[4]) a2_sr[0] <= a2;
    for (int k = 1; k < 4; k++) begin
      if (en[4+k]) a2_sr[k] <= a2_sr[k-1];
    end
    if (en[14]) x_sr[0] <= xg;
    if (en[16]) z_sr[0] <= z;
    for (int k = 1; k < 6; k++) begin
      if (en[14+k]) x_sr[k] <= x_sr[k-1];
      if (en[16+k]) z_sr[k] <= z_sr[k-1];
    end
  end

  // Pre-scale operands: cosine offset, degree scaling
  always_comb begin
    case (s_tuser)
      OP_COS_RAD: k0 = C_HALF_PI;
      OP_COS_DEG: k0 = C_NINETY;
      default:    k0 = C_NEG_ZERO;
    endcase
    k1 = (req_sr[1] == OP_SIN_DEG || req_sr[1] == OP_COS_DEG) ? C_DEG_RAD : C_ONE;
  end

  scu_fadd u_add_ofs (.clk(clk), .ctl('{en[0], en[1]}), .a(s_tdata), .b(k0), .y(a1));
  scu_fmul u_mul_deg (.clk(clk), .ctl('{en[2], en[3]}), .a(a1), .b(k1), .y(a2));

  // Reduce by a truncated multiple of two pi
  assign qv = fp_trunc(mq);

  scu_fmul u_mul_quo (.clk(clk), .ctl('{en[4], en[5]}), .a(C_INV_TWO_PI), .b(a2), .y(mq));
  scu_fmul u_mul_mul (.clk(clk), .ctl('{en[6], en[7]}), .a(qv), .b(C_NEG_TWO_PI), .y(pr));
  scu_fadd u_add_red (.clk(clk), .ctl('{en[8], en[9]}), .a(a2_sr[3]), .b(pr), .y(a3));

  // Fold into the half turn about zero, from -pi/2 to pi/2
  assign fb = fp_lt(a3, 32'h00000000) ? C_TWO_PI : C_NEG_ZERO;

  always_comb begin
    c_hi  = fp_lt(C_THR_HALF, a4);
    c_mid = fp_lt(C_HALF_PI, a4);
    if (c_hi) begin
      ga = a4;
      gb = C_NEG_TWO_PI;
    end else if (c_mid) begin
      ga = C_PI;
      gb = {~a4[31], a4[30:0]};
    end else begin
      ga = a4;
      gb = C_NEG_ZERO;
    end
  end

  scu_fadd u_add_neg (.clk(clk), .ctl('{en[10], en[11]}), .a(a3), .b(fb), .y(a4));
  scu_fadd u_add_fld (.clk(clk), .ctl('{en[12], en[13]}), .a(ga), .b(gb), .y(xg));

  // Odd polynomial in x
  scu_fmul u_mul_z  (.clk(clk), .ctl('{en[14], en[15]}), .a(xg), .b(xg), .y(z));
  scu_fmul u_mul_t1 (.clk(clk), .ctl('{en[16], en[17]}), .a(x_sr[1]), .b(z), .y(t1));
  scu_fmul u_mul_p3 (.clk(clk), .ctl('{en[18], en[19]}), .a(t1), .b(C_COEF3), .y(p3));
  scu_fmul u_mul_t2 (.clk(clk), .ctl('{en[18], en[19]}), .a(t1), .b(z_sr[1]), .y(t2));
  scu_fadd u_add_r1 (.clk(clk), .ctl('{en[20], en[21]}), .a(x_sr[5]), .b(p3), .y(r1));
  scu_fmul u_mul_p5 (.clk(clk), .ctl('{en[20], en[21]}), .a(t2), .b(C_COEF5), .y(p5));
  scu_fmul u_mul_t3 (.clk(clk), .ctl('{en[20], en[21]}), .a(t2), .b(z_sr[3]), .y(t3));
  scu_fadd u_add_r2 (.clk(clk), .ctl('{en[22], en[23]}), .a(r1), .b(p5), .y(r2));
  scu_fmul u_mul_p7 (.clk(clk), .ctl('{en[22], en[23]}), .a(t3), .b(C_COEF7), .y(p7));
  scu_fmul u_mul_t4 (.clk(clk), .ctl('{en[22], en[23]}), .a(t3), .b(z_sr[5]), .y(t4));
  scu_fadd u_add_r3 (.clk(clk), .ctl('{en[24], en[25]}), .a(r2), .b(p7), .y(r3));
  scu_fmul u_mul_p9 (.clk(clk), .ctl('{en[24], en[25]}), .a(t4), .b(C_COEF9), .y(p9));
  scu_fadd u_add_r4 (.clk(clk), .ctl('{en[26], en[27]}), .a(r3), .b(p9), .y(r4));

  // Clamp to the unit range and canonicalise NaN
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (fp_is_nan(r4)) begin
        res <= C_QNAN;
      end else if (fp_lt(r4, C_NEG_ONE)) begin
        res <= C_NEG_ONE;
      end else if (fp_lt(C_ONE, r4)) begin
        res <= C_ONE;
      end else begin
        res <= r4;
      end
    end
  end

  // Checks
  `SCU_AST_IMPL(a_ready_when_drained, !m_tvalid, s_tready)
  `SCU_AST_IMPL(a_nan_canonical, m_tvalid && (m_tdata[30:23] == 8'hFF), m_tdata == C_QNAN)
  `SCU_AST_IMPL(a_unit_range, m_tvalid && (m_tdata[30:23] != 8'hFF), m_tdata[30:0] <= 31'h3F800000)

endmodule

[hw/rtl/scu_fadd.sv]
// ---------------------------------------------------------------------------
// scu_fadd
// Two-stage single-precision adder: align and add, then round and pack.
// ---------------------------------------------------------------------------
module scu_fadd (
  input  logic              clk,
  input  scu_pkg::scu_ctl_t ctl,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       y
);
  import scu_pkg::*;

  scu_unp_t u;

  // Align and add, then round
  always_ff @(posedge clk) begin
    if (ctl.en_a) u <= fadd_pre(a, b);
    if (ctl.en_b) y <= fp_pack(u);
  end

endmodule

[hw/rtl/scu_fmul.sv]
// ---------------------------------------------------------------------------
// scu_fmul
// Two-stage single-precision multiplier: product, then round and pack.
// ---------------------------------------------------------------------------
module scu_fmul (
  input  logic              clk,
  input  scu_pkg::scu_ctl_t ctl,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       y
);
  import scu_pkg::*;

  scu_unp_t u;

  // Multiply mantissas, then round
  always_ff @(posedge clk) begin
    if (ctl.en_a) u <= fmul_pre(a, b);
    if (ctl.en_b) y <= fp_pack(u);
  end

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Sine/cosine unit testbench
// Streams angles with all four operation codes through the block. A bit-exact
// single-precision model predicts each result, and a scoreboard compares the
// results in order. Both sides idle at random, and the receiver stalls long
// enough to back the pipeline up.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scu_pkg::*;

  localparam int NUM_RANDOM  = 1500;
  localparam int CALM_FROM   = 1300;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_AT    = 700;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 40;

  // Single-precision constants of the algorithm
  localparam logic [31:0] F_PI       = 32'h40490FDA;
  localparam logic [31:0] F_TWO_PI   = 32'h40C90FDA;
  localparam logic [31:0] F_M2PI     = 32'hC0C90FDA;
  localparam logic [31:0] F_HALF_PI  = 32'h3FC90FDA;
  localparam logic [31:0] F_3HALF_PI = 32'h4096CBE4;
  localparam logic [31:0] F_INV_2PI  = 32'h3E22F984;
  localparam logic [31:0] F_DEG2RAD  = 32'h3C8EFA35;
  localparam logic [31:0] F_NINETY   = 32'h42B40000;
  localparam logic [31:0] F_K3       = 32'hBE2AAAAB;
  localparam logic [31:0] F_K5       = 32'h3C088889;
  localparam logic [31:0] F_K7       = 32'hB9500D01;
  localparam logic [31:0] F_K9       = 32'h3638EF1D;
  localparam logic [31:0] F_ONE      = 32'h3F800000;
  localparam logic [31:0] F_NEG_ONE  = 32'hBF800000;
  localparam logic [31:0] F_ZERO     = 32'h00000000;
  localparam logic [31:0] F_QNAN     = 32'h7FC00000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] angle_bits
  logic [1:0]  s_tuser;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] value_bits

  int  items_in;
  bit  calm;
  int  idle_cycles;

  sine_cosine_unit_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // --- single-precision arithmetic ----------------------------------------

  function automatic bit is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 0);
  endfunction

  // Significand with hidden bit, and exponent of its lowest bit
  function automatic logic [23:0] sig_of(logic [31:0] a);
    return {(a[30:23] != 0), a[22:0]};
  endfunction

  function automatic int lsb_exp(logic [31:0] a);
    return ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  // Round m * 2^e to nearest even and pack
  function automatic logic [31:0] round_pack(bit s, logic [127:0] m, int e);
    int           p, sh, be;
    logic [127:0] q, rem, half;
    longint       t;
    if (m == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    be = p + e + 127;
    sh = (be >= 1) ? p - 23 : -149 - e;
    if (sh >= 128) begin
      q = 0;
    end else if (sh > 0) begin
      q    = m >> sh;
      rem  = m & ((128'd1 << sh) - 1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end else begin
      q = m << (-sh);
    end
    if (be >= 1) begin
      t = longint'(be) * 64'd8388608 + longint'(q[24:0]) - 64'd8388608;
      if (t >= 64'h7F800000) return {s, 8'hFF, 23'd0};
    end else begin
      t = longint'(q[24:0]);
    end
    return {s, t[30:0]};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return F_QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    return round_pack(s, 128'(sig_of(a)) * 128'(sig_of(b)), lsb_exp(a) + lsb_exp(b));
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    logic [127:0] ma, mb, mr;
    int           ea, eb, d, e;
    bit           s;
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    ma = sig_of(a);
    mb = sig_of(b);
    ea = lsb_exp(a);
    eb = lsb_exp(b);
    // align; a far smaller operand only leaves a sticky bit
    if (ea >= eb) begin
      d = ea - eb;
      if (d > 60) begin
        ma = ma << 60; mb = (mb != 0); e = ea - 60;
      end else begin
        ma = ma << d; e = eb;
      end
    end else begin
      d = eb - ea;
      if (d > 60) begin
        mb = mb << 60; ma = (ma != 0); e = eb - 60;
      end else begin
        mb = mb << d; e = ea;
      end
    end
    if (a[31] == b[31]) begin
      mr = ma + mb; s = a[31];
    end else if (ma >= mb) begin
      mr = ma - mb; s = a[31];
    end else begin
      mr = mb - ma; s = b[31];
    end
    if (mr == 0) s = a[31] & b[31];
    return round_pack(s, mr, e);
  endfunction

  function automatic bit f_less(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 0;
    if (a[30:0] == 0 && b[30:0] == 0) return 0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic logic [31:0] f_trunc(logic [31:0] a);
    int sh;
    if (a[30:23] >= 8'd150) return a;
    if (a[30:23] < 8'd127) return {a[31], 31'd0};
    sh = 150 - int'(a[30:23]);
    return a & ~((32'd1 << sh) - 32'd1);
  endfunction

  // Expected result bits for one operation code and angle
  function automatic logic [31:0] predict_sincos(logic [1:0] op, logic [31:0] angle);
    logic [31:0] x, z, t, r;
    x = angle;
    if (op == OP_SIN_DEG || op == OP_COS_DEG) begin
      if (op == OP_COS_DEG) x = f_add(x, F_NINETY);
      x = f_mul(x, F_DEG2RAD);
    end else if (op == OP_COS_RAD) begin
      x = f_add(x, F_HALF_PI);
    end
    // remove whole turns
    x = f_add(x, f_mul(f_trunc(f_mul(F_INV_2PI, x)), F_M2PI));
    // fold into [-pi/2, pi/2]
    if (f_less(x, F_ZERO)) x = f_add(x, F_TWO_PI);
    if (f_less(F_3HALF_PI, x)) x = f_add(x, {~F_TWO_PI[31], F_TWO_PI[30:0]});
    else if (f_less(F_HALF_PI, x)) x = f_add(F_PI, {~x[31], x[30:0]});
    // odd Taylor polynomial
    z = f_mul(x, x);
    t = x;
    r = x;
    t = f_mul(t, z); r = f_add(r, f_mul(t, F_K3));
    t = f_mul(t, z); r = f_add(r, f_mul(t, F_K5));
    t = f_mul(t, z); r = f_add(r, f_mul(t, F_K7));
    t = f_mul(t, z); r = f_add(r, f_mul(t, F_K9));
    if (f_less(F_ONE, r)) r = F_ONE;
    if (f_less(r, F_NEG_ONE)) r = F_NEG_ONE;
    return is_nan(r) ? F_QNAN : r;
  endfunction

  // --- scoreboard ---------------------------------------------------------

  class sincos_scoreboard;
    logic [31:0] value_q[$];
    int          mismatches;

    function void note_angle(logic [1:0] op, logic [31:0] angle);
      value_q.push_back(predict_sincos(op, angle));
    endfunction

    function void check_value(logic [31:0] got);
      logic [31:0] want;
      if (value_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %08h", got);
        return;
      end
      want = value_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("value_bits mismatch: expected %08h, got %08h", want, got);
      end
    endfunction

    function int pending();
      return value_q.size();
    endfunction
  endclass

  sincos_scoreboard value_sb = new();

  // --- stimulus helpers ---------------------------------------------------

  // Offer one item and hold it until taken
  task automatic send_angle(logic [1:0] op, logic [31:0] angle);
    s_tvalid <= 1'b1;
    s_tdata  <= angle;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    value_sb.note_angle(op, angle);
    items_in++;
  endtask

  // Drop valid for a random burst
  task automatic sender_gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_angle();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(0, 9))
      0, 1:          ;                                        // any bit pattern
      2, 3, 4, 5, 6: a[30:23] = 8'($urandom_range(100, 136)); // ordinary angles
      7:             a[30:23] = 8'($urandom_range(118, 133));
      8:             a[30:23] = 8'($urandom_range(137, 254)); // huge
      default: begin
        case ($urandom_range(0, 3))
          0: a[30:0] = 31'd0;
          1: a[30:0] = {8'hFF, 23'd0};
          2: a[30:23] = 8'hFF;
          default: a[30:23] = 8'd0;                           // subnormal
        endcase
      end
    endcase
    return a;
  endfunction

  // --- clock, watchdog, receiver -----------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when nothing moves for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sine_cosine_unit_core verification failed");
        $finish;
      end
    end
  end

  // Take results, stall in bursts, and once hold off long enough to fill up
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) value_sb.check_value(m_tdata);
      if (!held && items_in >= HOLD_AT) begin
        held       = 1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --- main sequence ------------------------------------------------------

  initial begin
    logic [31:0] edge_angles[] = '{
      32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, F_PI, F_HALF_PI,
      32'hC0490FDA, 32'h42B40000, 32'h43340000, 32'h43870000, 32'h43B40000,
      32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001, 32'h807FFFFF, 32'h7F800000,
      32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF, 32'h4B000000, 32'h7149F2CA,
      32'hC3B3FFFF};
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_SIN_RAD;
    m_tready = 1'b0;
    calm     = 0;
    items_in = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edge angles, each with a rotating operation code
    foreach (edge_angles[k]) send_angle(2'(k), edge_angles[k]);
    send_angle(OP_SIN_RAD, F_3HALF_PI);
    send_angle(OP_COS_DEG, 32'hC2B40000);
    send_angle(OP_SIN_DEG, 32'h3F800000);

    // random, with gaps in alternating windows and none near the end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= CALM_FROM);
      send_angle(2'($urandom_range(0, 3)), pick_angle());
      if (n == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (value_sb.pending() != 0) @(posedge clk);
      end else if (!calm && ((n / 100) % 2 == 0) && $urandom_range(0, 3) == 0) begin
        sender_gap();
      end
    end
    s_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (value_sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (value_sb.mismatches == 0 && value_sb.pending() == 0) begin
      $display("sine_cosine_unit_core verification clean");
    end else begin
      $display("sine_cosine_unit_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/scu_pkg.sv
hw/rtl/scu_fadd.sv
hw/rtl/scu_fmul.sv
hw/rtl/sine_cosine_unit_core.sv
tb/testbench.sv
